// ===== design/sorted_set_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_set_table_top_assert
// assertion macros for the sorted set table
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_TOP_ASSERT_SVH
`define SORTED_SET_TABLE_TOP_ASSERT_SVH

// condition that holds at every edge out of reset
`define SST_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in one cycle implies a condition in the next
`define SST_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// types and constants shared by the sorted set table cells and top level
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               present;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_word_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell
// one entry of the sorted chain: compares against the broadcast value and
// shifts toward its neighbors on insert or remove
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic                              clk,
  input  logic                              live,
  input  logic                              left_lt,
  input  logic signed [sst_pkg::VALUE_W-1:0] left_value,
  input  logic signed [sst_pkg::VALUE_W-1:0] right_value,
  input  sst_pkg::cell_cmd_t                cmd,
  output logic                              lt,
  output logic                              eq,
  output logic signed [sst_pkg::VALUE_W-1:0] value
);
  import sst_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  assign lt    = live && (value_r < cmd.value);
  assign eq    = live && (value_r == cmd.value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins && !lt) begin
      // the first cell at or above the new value takes it, the rest move up
      value_nxt = left_lt ? cmd.value : left_value;
    end else if (cmd.rem && !lt) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== design/sorted_set_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_set_table_top
// set of distinct signed values kept in ascending order in a chain of cells
// ----------------------------------------------------------------------------
//   channel | dir | handshake         | payload
//   in      | in  | in_valid/in_stall | in_word  (opcode, value)
//   out     | out | out_valid/out_stall | out_word (present, status, count)
//
// one word per cycle unless in_stall is high: every cell compares against the
// value in parallel and shifts in the same cycle, so the result register is loaded
// as the word is accepted; the compare plus the membership or-reduction sets the path
// reset clears the count and the output valid; entry contents stay undefined
// a stalled result holds in the output register; input stalls only while it
// is full and not being taken
module sorted_set_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::out_word_t out_word
);
  import sst_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic                      acc;
  logic                      present;
  logic                      full;
  logic [1:0]                status;
  cell_cmd_t                 cmd;
  logic [CAPACITY-1:0]       lt_v;
  logic [CAPACITY-1:0]       eq_v;
  logic [CAPACITY-1:0]       live_v;
  logic [CAPACITY-1:0]       left_lt_v;
  logic signed [VALUE_W-1:0] val_v       [CAPACITY];
  logic signed [VALUE_W-1:0] left_val_v  [CAPACITY];
  logic signed [VALUE_W-1:0] right_val_v [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live_v[i] = CNT_W'(i) < count_r;
    if (i == 0) begin : g_first
      assign left_lt_v[i]  = 1'b1;
      assign left_val_v[i] = cmd.value;
    end else begin : g_mid
      assign left_lt_v[i]  = lt_v[i-1];
      assign left_val_v[i] = val_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val_v[i] = val_v[i];
    end else begin : g_next
      assign right_val_v[i] = val_v[i+1];
    end

    sst_cell u_cell (
      .clk         (clk),
      .live        (live_v[i]),
      .left_lt     (left_lt_v[i]),
      .left_value  (left_val_v[i]),
      .right_value (right_val_v[i]),
      .cmd         (cmd),
      .lt          (lt_v[i]),
      .eq          (eq_v[i]),
      .value       (val_v[i])
    );
  end

  always_comb begin
    present   = |eq_v;
    full      = count_r == CNT_W'(CAPACITY);
    cmd.value = in_word.value;
    cmd.ins   = acc && (in_word.opcode == OP_INSERT) && !present && !full;
    cmd.rem   = acc && (in_word.opcode == OP_REMOVE) && present;
    status    = ST_DONE;
    if (in_word.opcode == OP_INSERT) begin
      if (present) begin
        status = ST_NOCHANGE;
      end else if (full) begin
        status = ST_FULL;
      end
    end else if (in_word.opcode == OP_REMOVE) begin
      if (!present) begin
        status = ST_NOCHANGE;
      end
    end
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_word_nxt.present = present;
    out_word_nxt.status  = status;
    out_word_nxt.count   = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "sorted_set_table_top_assert.svh"

  `SST_ASSERT(a_count_cap, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SST_ASSERT(a_full_status, !(acc && status == ST_FULL) || full, "full status while not full")
  `SST_ASSERT_NEXT(a_rem_count, cmd.rem, count_r == $past(count_r) - CNT_W'(1), "remove count")
  `SST_ASSERT_NEXT(a_ins_count, cmd.ins, count_r == $past(count_r) + CNT_W'(1), "insert count")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sorted set table against a behavioral copy of the set
// ----------------------------------------------------------------------------
// a short directed table covers the empty set, the value extremes, the spare
// opcode, duplicates and the full set. A random part of fill and drain
// stretches follows. Each accepted input word runs through the set copy, and
// each accepted output word is compared with the oldest expected word. The
// sender and the receiver idle at different rates from phase to phase.
module tb_top;
  import sst_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int POOL_N       = 24;
  localparam int ITEMS_PHASE  = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // behavioral copy of the set
  logic signed [VALUE_W-1:0] set_members [CAPACITY];
  int                        set_count = 0;

  out_word_t expected_words[$];
  dir_row_t  dir_rows[$];
  logic signed [VALUE_W-1:0] value_pool [POOL_N];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int fail_count  = 0;
  int shown_count = 0;
  int quiet_cycles = 0;

  sorted_set_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // applies one operation to the set copy and returns the word it should give
  function automatic out_word_t predict_set_op(in_word_t w);
    out_word_t r;
    logic signed [VALUE_W-1:0] v;
    int pos;
    bit hit;
    v = w.value;
    pos = 0;
    while (pos < set_count && set_members[pos] < v) pos++;
    hit = (pos < set_count) && (set_members[pos] == v);
    r.present = hit;
    r.status  = ST_DONE;
    if (w.opcode == OP_INSERT) begin
      if (hit) begin
        r.status = ST_NOCHANGE;
      end else if (set_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int k = set_count; k > pos; k--) set_members[k] = set_members[k-1];
        set_members[pos] = v;
        set_count++;
      end
    end else if (w.opcode == OP_REMOVE) begin
      if (!hit) begin
        r.status = ST_NOCHANGE;
      end else begin
        for (int k = pos; k + 1 < set_count; k++) set_members[k] = set_members[k+1];
        set_count--;
      end
    end
    r.count = COUNT_W'(set_count);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic signed [VALUE_W-1:0] val,
                                  bit typed, logic present, logic [1:0] status,
                                  int count);
    dir_row_t row;
    row.word.opcode  = op;
    row.word.value   = val;
    row.typed        = typed;
    row.want.present = present;
    row.want.status  = status;
    row.want.count   = COUNT_W'(count);
    dir_rows.push_back(row);
  endfunction

  // fill stretches favor inserts, drain stretches favor removes
  function automatic in_word_t pick_word(bit fill_bias);
    in_word_t w;
    int r;
    int sel;
    r = $urandom_range(99);
    if (fill_bias) begin
      w.opcode = (r < 60) ? OP_INSERT : (r < 85) ? OP_REMOVE : (r < 96) ? OP_LOOKUP : OP_SPARE;
    end else begin
      w.opcode = (r < 30) ? OP_INSERT : (r < 75) ? OP_REMOVE : (r < 95) ? OP_LOOKUP : OP_SPARE;
    end
    sel = $urandom_range(99);
    if (sel < 65) begin
      w.value = value_pool[$urandom_range(POOL_N-1)];
    end else if (sel < 85 && set_count > 0) begin
      w.value = set_members[$urandom_range(set_count-1)];
    end else begin
      w.value = $urandom;
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic report_mismatch(string what);
    fail_count++;
    if (shown_count < MAX_SHOWN) begin
      shown_count++;
      $display("mismatch: %s", what);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word present=%0d status=%0d count=%0d",
                                  out_word.present, out_word.status, out_word.count));
      end else begin
        want = expected_words.pop_front();
        if (out_word.present !== want.present || out_word.status !== want.status ||
            out_word.count !== want.count) begin
          report_mismatch($sformatf(
            "expected present=%0d status=%0d count=%0d, got present=%0d status=%0d count=%0d",
            want.present, want.status, want.count,
            out_word.present, out_word.status, out_word.count));
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_word_t w;
    dir_row_t row;
    out_word_t got;

    // empty set, extremes, duplicate, spare opcode
    add_row(OP_LOOKUP, 32'sd0, 1, 1'b0, ST_DONE, 0);
    add_row(OP_REMOVE, 32'sd0, 1, 1'b0, ST_NOCHANGE, 0);
    add_row(OP_INSERT, VAL_MAX, 1, 1'b0, ST_DONE, 1);
    add_row(OP_INSERT, VAL_MIN, 1, 1'b0, ST_DONE, 2);
    add_row(OP_INSERT, VAL_MIN, 1, 1'b1, ST_NOCHANGE, 2);
    add_row(OP_SPARE,  VAL_MAX, 1, 1'b1, ST_DONE, 2);
    add_row(OP_REMOVE, VAL_MAX, 1, 1'b1, ST_DONE, 1);
    add_row(OP_LOOKUP, VAL_MAX, 1, 1'b0, ST_DONE, 1);
    // fill up to capacity with mixed signs
    for (int k = 1; k < CAPACITY; k++) begin
      add_row(OP_INSERT, (k % 2) ? -(k * 32'sh0123_4567) : k * 32'sh0123_4567,
              0, 1'b0, ST_DONE, 0);
    end
    // full set: absent insert rejected, present insert still no change
    add_row(OP_INSERT, 32'sd12345, 1, 1'b0, ST_FULL, CAPACITY);
    add_row(OP_INSERT, VAL_MIN, 1, 1'b1, ST_NOCHANGE, CAPACITY);
    add_row(OP_REMOVE, VAL_MIN, 1, 1'b1, ST_DONE, CAPACITY - 1);

    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    value_pool[5] = VAL_MIN + 1;
    value_pool[6] = VAL_MAX - 1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int p = 7; p < POOL_N; p++) value_pool[p] = $urandom;
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          row = dir_rows[i];
          send_word(row.word);
          got = predict_set_op(row.word);
          expected_words.push_back(row.typed ? row.want : got);
        end
      end
      for (int i = 0; i < ITEMS_PHASE; i++) begin
        w = pick_word(((i / 25) % 2) == 0);
        send_word(w);
        expected_words.push_back(predict_set_op(w));
      end
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
